[rtl/irpd_pkg.sv]
// irpd_pkg: shared types and constants for the pulse-distance ir decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package irpd_pkg;

   // field widths
   localparam int unsigned CODE_W     = 32;
   localparam int unsigned TS_W       = 32;
   localparam int unsigned CFG_W      = 16;
   localparam int unsigned IDX_W      = $clog2(CODE_W);
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // item opcodes
   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_START_MIN = 2'd0;
   localparam logic [1:0] REG_START_MAX = 2'd1;
   localparam logic [1:0] REG_GAP_MAX   = 2'd2;
   localparam logic [1:0] REG_ONE_THR   = 2'd3;

   // register reset values in microseconds
   localparam logic [CFG_W-1:0] START_MIN_RST = 16'd3000;
   localparam logic [CFG_W-1:0] START_MAX_RST = 16'd5000;
   localparam logic [CFG_W-1:0] GAP_MAX_RST   = 16'd5000;
   localparam logic [CFG_W-1:0] ONE_THR_RST   = 16'd1000;

   typedef struct packed {
      logic [CFG_W-1:0] start_min_us;
      logic [CFG_W-1:0] start_max_us;
      logic [CFG_W-1:0] gap_max_us;
      logic [CFG_W-1:0] one_threshold_us;
   } cfg_type;

   typedef struct packed {
      logic            op;
      logic            level;
      logic [TS_W-1:0] timestamp_us;
   } item_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              receiving;
   } result_type;

endpackage

`default_nettype wire

[rtl/irpd_csr.sv]
// irpd_csr: apb-style register file holding the four timing thresholds
// depends on irpd_pkg
`default_nettype none

module irpd_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [irpd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [irpd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [irpd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                              csr_pready,
   output      irpd_pkg::cfg_type                 cfg
);
   import irpd_pkg::*;

   cfg_type          cfg_ff;
   logic             wr_en;
   logic [1:0]       reg_idx;
   logic [CFG_W-1:0] wdata;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign wdata      = csr_pwdata[CFG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_min_us     <= START_MIN_RST;
         cfg_ff.start_max_us     <= START_MAX_RST;
         cfg_ff.gap_max_us       <= GAP_MAX_RST;
         cfg_ff.one_threshold_us <= ONE_THR_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_START_MIN: cfg_ff.start_min_us     <= wdata;
            REG_START_MAX: cfg_ff.start_max_us     <= wdata;
            REG_GAP_MAX:   cfg_ff.gap_max_us       <= wdata;
            REG_ONE_THR:   cfg_ff.one_threshold_us <= wdata;
            default:       cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_START_MIN: csr_prdata = CSR_DATA_W'(cfg_ff.start_min_us);
         REG_START_MAX: csr_prdata = CSR_DATA_W'(cfg_ff.start_max_us);
         REG_GAP_MAX:   csr_prdata = CSR_DATA_W'(cfg_ff.gap_max_us);
         REG_ONE_THR:   csr_prdata = CSR_DATA_W'(cfg_ff.one_threshold_us);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/irpd_decode.sv]
// irpd_decode: frame state registers and the per-item decode step
// depends on irpd_pkg
`default_nettype none

module irpd_decode #(
   parameter int unsigned FRAME_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire irpd_pkg::item_type   item,
   input  wire irpd_pkg::cfg_type    cfg,
   output      irpd_pkg::result_type result
);
   import irpd_pkg::*;

   localparam int unsigned BL_W = $clog2(FRAME_BITS + 1);

   logic              started_ff,     started_in;
   logic [TS_W-1:0]   last_fall_ff,   last_fall_in;
   logic [TS_W-1:0]   last_rise_ff,   last_rise_in;
   logic [CODE_W-1:0] shift_ff,       shift_in;
   logic [BL_W-1:0]   bits_left_ff,   bits_left_in;
   logic [CODE_W-1:0] held_ff,        held_in;

   logic [TS_W-1:0]   dur_rise;
   logic [TS_W-1:0]   dur_fall;
   logic [BL_W-1:0]   bits_dec;
   logic [IDX_W-1:0]  bit_idx;

   assign dur_rise = item.timestamp_us - last_fall_ff;
   assign dur_fall = item.timestamp_us - last_rise_ff;
   assign bits_dec = bits_left_ff - BL_W'(1);
   assign bit_idx  = IDX_W'(bits_dec);

   always_comb begin
      logic [CODE_W-1:0] shift_next;
      logic [BL_W-1:0]   bits_next;

      started_in   = started_ff;
      last_fall_in = last_fall_ff;
      last_rise_in = last_rise_ff;
      shift_in     = shift_ff;
      bits_left_in = bits_left_ff;
      held_in      = held_ff;
      shift_next   = shift_ff;
      bits_next    = bits_left_ff;

      if (step_en) begin
         case (item.op)
            OP_FETCH: begin
               held_in = '0;
            end
            OP_EDGE: begin
               if (item.level) begin
                  // rising edge ends a low: maybe the start pulse
                  last_rise_in = item.timestamp_us;
                  if (!started_ff &&
                      dur_rise >= TS_W'(cfg.start_min_us) &&
                      dur_rise <= TS_W'(cfg.start_max_us)) begin
                     started_in   = 1'b1;
                     shift_in     = '0;
                     bits_left_in = BL_W'(FRAME_BITS);
                  end
               end else begin
                  // falling edge ends a high: a data bit or an abort
                  last_fall_in = item.timestamp_us;
                  if (dur_fall > TS_W'(cfg.gap_max_us)) begin
                     started_in = 1'b0;
                  end else if (started_ff) begin
                     if (bits_left_ff != '0) begin
                        if (dur_fall > TS_W'(cfg.one_threshold_us)) begin
                           shift_next[bit_idx] = 1'b1;
                        end
                        bits_next = bits_dec;
                     end
                     shift_in     = shift_next;
                     bits_left_in = bits_next;
                     // latch only into an empty holding register
                     if (bits_next == '0 && held_ff == '0) begin
                        held_in    = shift_next;
                        started_in = 1'b0;
                     end
                  end
               end
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         last_fall_ff <= '0;
         last_rise_ff <= '0;
         shift_ff     <= '0;
         bits_left_ff <= '0;
         held_ff      <= '0;
      end else begin
         started_ff   <= started_in;
         last_fall_ff <= last_fall_in;
         last_rise_ff <= last_rise_in;
         shift_ff     <= shift_in;
         bits_left_ff <= bits_left_in;
         held_ff      <= held_in;
      end
   end

   assign result = {((step_en && item.op == OP_FETCH) ? held_ff : {CODE_W{1'b0}}),
                    started_in};

endmodule

`default_nettype wire

[rtl/ir_pulse_distance_decoder_core.sv]
// ir_pulse_distance_decoder_core: top level of the pulse-distance ir decoder
// depends on irpd_pkg, irpd_csr and irpd_decode
`default_nettype none

// Decodes pulse-distance infrared frames from timestamped pin edges. Each
// req_ transfer is either an edge (op edge, new pin level, free-running
// microsecond timestamp) or a fetch (op fetch) that returns and clears the
// held code. Every item gives exactly one rsp_ transfer: code is the held
// code on a fetch (zero when empty) and zero on an edge; receiving is 1 while
// a frame is in progress after that item. Durations are timestamp differences
// modulo 2^32, so the timestamp counter may wrap freely. A low between
// start_min_us and start_max_us (inclusive) ending in a rising edge starts a
// frame; each following high decodes one bit, msb first (1 when longer than
// one_threshold_us); a high longer than gap_max_us aborts. After FRAME_BITS
// bits the word is latched only if the holding register is empty; a word of
// zero reads as empty. Rate: one item per clock cycle sustained while rsp_stall
// stays low. An accepted item is held in the input register, then the single
// decode step updates the frame state and loads the result register, and the
// result shows on rsp_ from that register. The input register keeps taking
// an item while a result waits under rsp_stall, and stalls only when both
// hold one. Thresholds are written through the csr_ port while the block is
// idle; the user is bound to this, as the block itself does not enforce it.

module ir_pulse_distance_decoder_core #(
   parameter int unsigned FRAME_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic                              req_op,
   input  wire logic                              req_level,
   input  wire logic [irpd_pkg::TS_W-1:0]         req_timestamp_us,
   // result channel
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic [irpd_pkg::CODE_W-1:0]       rsp_code,
   output      logic                              rsp_receiving,
   // register port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [irpd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [irpd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [irpd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                              csr_pready
);
   import irpd_pkg::*;

   cfg_type    cfg;
   item_type   item_ff,  item_in;
   logic       in_vld_ff, in_vld_in;
   result_type res_ff;
   result_type step_res;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       advance;
   logic       req_take;

   irpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // the step runs when an item is held and the result slot is free
   // or being emptied by this cycle's transfer
   assign advance   = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   irpd_decode #(
      .FRAME_BITS (FRAME_BITS)
   ) u_decode (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (step_res)
   );

   always_comb begin
      item_in.op           = req_op;
      item_in.level        = req_level;
      item_in.timestamp_us = req_timestamp_us;

      // input register: refilled on a transfer, emptied when stepped
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end

      // result register: loaded by the step, emptied by a transfer out
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= step_res;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_code      = res_ff.code;
   assign rsp_receiving = res_ff.receiving;

endmodule

`default_nettype wire

[rtl/irpd_checker.sv]
// irpd_checker: port-level assertions for the ir decoder top level
// depends on irpd_pkg; bound to ir_pulse_distance_decoder_core below
`default_nettype none

module irpd_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic [irpd_pkg::CODE_W-1:0]       rsp_code,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [irpd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [irpd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  wire logic [irpd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  wire logic                              csr_pready
);
   import irpd_pkg::*;

   // no result may be pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // a stalled result keeps its code
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code))
      else $error("stalled result changed");

   // a fresh result needs an input transfer through the input register before it
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without an input transfer");

   // a register reads back the low half of what was just written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready)
      ##1 (csr_psel && !csr_pwrite && csr_paddr[3:2] == $past(csr_paddr[3:2]))
      |-> csr_prdata == CSR_DATA_W'($past(csr_pwdata[CFG_W-1:0])))
      else $error("register readback mismatch");

endmodule

bind ir_pulse_distance_decoder_core irpd_checker u_irpd_checker (.*);

`default_nettype wire
